/* rtl/core/cce_pkg.sv */
package cce_pkg;

    typedef logic [23:0] pix_t;

    // one column of source pixels: two stored rows and the incoming row
    typedef struct packed {
        pix_t a;
        pix_t b;
        pix_t x;
    } col_t;

    // one classified input pixel; mask bits in emission order:
    // prev row left, prev row right edge, last row left, last row right edge
    typedef struct packed {
        logic [3:0] mask;
        logic       r_eq0;
        logic       r_eq1;
        logic       c_eq0;
        logic       c_eq1;
        col_t       cur;
        col_t       p1;
        col_t       p2;
    } job_t;

    typedef struct packed {
        logic [2:0][23:0] krow;
        logic             binarize;
        logic [7:0]       threshold;
    } filt_cfg_t;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4,
        REG_BINARIZE      = 3'd5,
        REG_THRESHOLD     = 3'd6
    } reg_idx_t;

    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [15:0] RST_FRAME_HEIGHT  = 16'd480;
    localparam logic [23:0] RST_KERNEL_TOP    = 24'd0;
    localparam logic [23:0] RST_KERNEL_MIDDLE = 24'd256;
    localparam logic [23:0] RST_KERNEL_BOTTOM = 24'd0;
    localparam logic [7:0]  RST_THRESHOLD     = 8'd128;
    localparam logic [7:0]  COL_MAX           = 8'd255;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

endpackage

/* rtl/core/cce_front.sv */
module cce_front
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [11:0] frame_width,
    input  logic [15:0] frame_height,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = CW + 1;
    localparam int DEPTH = 2 ** AW;

    logic [CW-1:0] w_m1;
    logic [15:0]   h_m1;
    logic [CW-1:0] col_reg, col_next, c;
    logic [15:0]   row_reg, row_next, r;
    logic          accept;
    logic [AW-1:0] addr_a, addr_b;

    logic          s1_valid_reg, s1_valid_next;
    logic [3:0]    s1_mask_reg;
    logic          s1_r_eq0_reg, s1_r_eq1_reg, s1_c_eq0_reg, s1_c_eq1_reg;
    pix_t          s1_x_reg;
    pix_t          rd_a_reg, rd_b_reg;
    col_t          p1_reg, p2_reg;
    col_t          cur;

    pix_t          mem [DEPTH];

    always_comb
    begin
        if (frame_width == 12'd0)
            w_m1 = '0;
        else if (32'(frame_width) > MAX_WIDTH)
            w_m1 = CW'(MAX_WIDTH - 1);
        else
            w_m1 = CW'(frame_width - 12'd1);
        h_m1 = (frame_height == 16'd0) ? 16'd0 : frame_height - 16'd1;
    end

    // wrap counters that lie outside the current geometry
    always_comb
    begin
        c = col_reg;
        r = row_reg;
        if (col_reg > w_m1)
        begin
            c = '0;
            r = row_reg + 16'd1;
        end
        if (r > h_m1)
            r = 16'd0;
        col_next = c + CW'(1);
        row_next = r;
        if (c == w_m1)
        begin
            col_next = '0;
            row_next = (r == h_m1) ? 16'd0 : r + 16'd1;
        end
    end

    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = s1_valid_reg && !q_full;

    // row r overwrites row r-2 in the same slot
    assign addr_a = {r[0], c};
    assign addr_b = {~r[0], c};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[addr_a] <= {blue_in, green_in, red_in};
            rd_a_reg    <= mem[addr_a];
            rd_b_reg    <= mem[addr_b];
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= {blue_in, green_in, red_in};
            s1_mask_reg  <= {(r == h_m1) && (c == w_m1), (r == h_m1) && (c != '0),
                             (r != 16'd0) && (c == w_m1), (r != 16'd0) && (c != '0)};
            s1_r_eq0_reg <= (r == 16'd0);
            s1_r_eq1_reg <= (r == 16'd1);
            s1_c_eq0_reg <= (c == '0);
            s1_c_eq1_reg <= (c == CW'(1));
        end
        if (q_push)
        begin
            p1_reg <= cur;
            p2_reg <= p1_reg;
        end
    end

    assign cur = '{a: rd_a_reg, b: rd_b_reg, x: s1_x_reg};

    always_comb
    begin
        q_job.mask  = s1_mask_reg;
        q_job.r_eq0 = s1_r_eq0_reg;
        q_job.r_eq1 = s1_r_eq1_reg;
        q_job.c_eq0 = s1_c_eq0_reg;
        q_job.c_eq1 = s1_c_eq1_reg;
        q_job.cur   = cur;
        q_job.p1    = p1_reg;
        q_job.p2    = p2_reg;
    end

endmodule

/* rtl/core/cce_queue.sv */
module cce_queue
    import cce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

/* rtl/core/cce_back.sv */
module cce_back
    import cce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  filt_cfg_t  cfg,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic       last_of_run,
    output logic       frame_end
);

    logic [3:0]  done_reg, done_next;
    logic [3:0]  remain, sel;
    logic        have, last_sel, pass_last, item_edge;
    logic        out_load, p_load;
    col_t        col_l, col_m, col_r;
    col_t [2:0]  cols;
    logic [2:0][2:0][23:0] win;

    logic                     p_valid_reg, p_last_reg, p_fend_reg;
    logic signed [16:0]       prod_reg [3][3][3];
    logic signed [16:0]       prod_next [3][3][3];
    logic                     out_valid_reg;
    logic [7:0]               red_reg, green_reg, blue_reg;
    logic                     last_reg, fend_reg;
    logic [2:0][7:0]          sat;
    logic signed [20:0]       sum [3];
    logic                     white;

    assign remain    = head_valid ? (head_job.mask & ~done_reg) : 4'd0;
    assign sel       = remain & (~remain + 4'd1);
    assign have      = (remain != 4'd0);
    assign last_sel  = (remain == sel);
    assign pass_last = sel[2] | sel[3];
    assign item_edge = sel[1] | sel[3];

    assign out_load = !out_valid_reg || !out_stall;
    assign p_load   = !p_valid_reg || out_load;
    assign pop      = head_valid && (!have || (p_load && last_sel));

    always_comb
    begin
        done_next = done_reg;
        if (pop)
            done_next = 4'd0;
        else if (have && p_load)
            done_next = done_reg | sel;
    end

    // column clamp at left and right frame edges
    always_comb
    begin
        if (item_edge)
        begin
            col_l = head_job.c_eq0 ? head_job.cur : head_job.p1;
            col_m = head_job.cur;
            col_r = head_job.cur;
        end
        else
        begin
            col_l = head_job.c_eq1 ? head_job.p1 : head_job.p2;
            col_m = head_job.p1;
            col_r = head_job.cur;
        end
        cols = {col_r, col_m, col_l};
    end

    // row clamp at top and bottom frame edges
    always_comb
    begin
        for (int dx = 0; dx < 3; dx++)
        begin
            if (pass_last)
            begin
                win[0][dx] = head_job.r_eq0 ? cols[dx].x : cols[dx].b;
                win[1][dx] = cols[dx].x;
                win[2][dx] = cols[dx].x;
            end
            else
            begin
                win[0][dx] = head_job.r_eq1 ? cols[dx].b : cols[dx].a;
                win[1][dx] = cols[dx].b;
                win[2][dx] = cols[dx].x;
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++)
                    prod_next[ch][dy][dx] = 17'($signed(cfg.krow[dy][8*dx +: 8])
                                               * $signed({1'b0, win[dy][dx][8*ch +: 8]}));
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++)
                    sum[ch] = sum[ch] + 21'(prod_reg[ch][dy][dx]);
            if (sum[ch] < 0)
                sat[ch] = 8'd0;
            else if (sum[ch] > 21'sd255)
                sat[ch] = COL_MAX;
            else
                sat[ch] = sum[ch][7:0];
        end
        white = (sat[0] > cfg.threshold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 4'd0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (p_load)
                p_valid_reg <= have;
            if (out_load)
                out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            prod_reg   <= prod_next;
            p_last_reg <= last_sel;
            p_fend_reg <= sel[3];
        end
        if (out_load)
        begin
            red_reg   <= cfg.binarize ? (white ? COL_MAX : 8'd0) : sat[0];
            green_reg <= cfg.binarize ? (white ? COL_MAX : 8'd0) : sat[1];
            blue_reg  <= cfg.binarize ? (white ? COL_MAX : 8'd0) : sat[2];
            last_reg  <= p_last_reg;
            fend_reg  <= p_fend_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_out     = red_reg;
    assign green_out   = green_reg;
    assign blue_out    = blue_reg;
    assign last_of_run = last_reg;
    assign frame_end   = fend_reg;

endmodule

/* rtl/core/conv3x3_clamp_edge_filter_top.sv */
// channel  direction  handshake              payload
// in       to block   in_valid / in_stall    red_in, green_in, blue_in
// out      from block out_valid / out_stall  red_out, green_out, blue_out,
//                                            last_of_run, frame_end
// cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel is taken per clock unless in_stall; each result leaves one per clock
// unless out_stall, via front, queue, product and result registers. Rate is set
// by the single output port of the convolution pipeline: up to four results fall
// due at row ends, and a four-entry queue absorbs them while the input runs on.
// Reset clears counters and valids; the line store needs no clearing pass.
// out_stall holds the result register and backs up through queue to in_stall.
module conv3x3_clamp_edge_filter_top
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        last_of_run,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic [11:0] frame_width_reg;
    logic [15:0] frame_height_reg;
    filt_cfg_t   cfg_reg;
    logic        q_full, q_push, q_pop, q_valid;
    job_t        push_job, head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            cfg_reg.krow[0]    <= RST_KERNEL_TOP;
            cfg_reg.krow[1]    <= RST_KERNEL_MIDDLE;
            cfg_reg.krow[2]    <= RST_KERNEL_BOTTOM;
            cfg_reg.binarize   <= 1'b0;
            cfg_reg.threshold  <= RST_THRESHOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[11:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[15:0];
                REG_KERNEL_TOP:    cfg_reg.krow[0]   <= cfg_data;
                REG_KERNEL_MIDDLE: cfg_reg.krow[1]   <= cfg_data;
                REG_KERNEL_BOTTOM: cfg_reg.krow[2]   <= cfg_data;
                REG_BINARIZE:      cfg_reg.binarize  <= cfg_data[0];
                REG_THRESHOLD:     cfg_reg.threshold <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    cce_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    cce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    cce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (q_valid),
        .head_job    (head_job),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

/* rtl/core/cce_port_chk.sv */
module cce_port_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  red_out,
    input logic [7:0]  green_out,
    input logic [7:0]  blue_out,
    input logic        last_of_run,
    input logic        frame_end
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(last_of_run) && $stable(frame_end))
        else $error("stalled result changed");

    // the bottom-right result closes its run
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> last_of_run)
        else $error("frame_end without last_of_run");

    // results of one run leave back to back
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside a run");

endmodule

bind conv3x3_clamp_edge_filter_top cce_port_chk u_port_chk (.*);
